// ===== hdl/spi_rtc_register_port_core_assert.svh =====
// Assertion macros for the SPI RTC register port.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SPI_RTC_REGISTER_PORT_CORE_ASSERT_SVH
`define SPI_RTC_REGISTER_PORT_CORE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define SRTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define SRTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/srtc_pkg.sv =====
// Shared types, constants and the BCD helper for the SPI RTC register port.
// No dependencies.
`timescale 1ns / 1ps

package srtc_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_DESELECT = 2'd0;
  localparam logic [1:0] OP_SELECT   = 2'd1;
  localparam logic [1:0] OP_TRANSFER = 2'd2;

  // Register map
  localparam logic [4:0] CONTROL_REG = 5'h0F;
  localparam int unsigned WP_BIT     = 6;
  localparam int unsigned RF_DEPTH   = 32;
  localparam int unsigned URAM_DEPTH = 96;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] YEAR_BASE   = 8'd100;

  // Time registers at the bottom of the register file
  localparam logic [2:0] REG_SECONDS = 3'd0;
  localparam logic [2:0] REG_MINUTES = 3'd1;
  localparam logic [2:0] REG_HOURS   = 3'd2;
  localparam logic [2:0] REG_WEEKDAY = 3'd3;
  localparam logic [2:0] REG_DAY     = 3'd4;
  localparam logic [2:0] REG_MONTH   = 3'd5;
  localparam logic [2:0] REG_YEAR    = 3'd6;

  typedef struct packed {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
  } tod_t;

  typedef struct packed {
    logic       en;
    logic [6:0] addr;
    logic [7:0] data;
  } wr_cmd_t;

  // Byte to BCD, tens digit kept to four bits; divide by ten via 205/2048
  function automatic logic [7:0] bcd8(logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0]  ones;
    prod = 16'(v) * 16'd205;
    tens = prod[15:11];
    ones = v - 8'(8'(tens) * 8'd10);
    return {tens[3:0], ones[3:0]};
  endfunction

endpackage

// ===== hdl/srtc_in_if.sv =====
// Input channel of the SPI RTC register port: handshake plus one bus item.
// No dependencies.
`timescale 1ns / 1ps

interface srtc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_in;
  logic [5:0] time_seconds;
  logic [5:0] time_minutes;
  logic [4:0] time_hours;
  logic [2:0] time_weekday;
  logic [4:0] time_day;
  logic [3:0] time_month;
  logic [7:0] time_year;

  modport source (
    output valid, operation, data_in, time_seconds, time_minutes, time_hours,
           time_weekday, time_day, time_month, time_year,
    input  ready
  );

  modport sink (
    input  valid, operation, data_in, time_seconds, time_minutes, time_hours,
           time_weekday, time_day, time_month, time_year,
    output ready
  );
endinterface

// ===== hdl/srtc_out_if.sv =====
// Output channel of the SPI RTC register port: handshake plus one result byte.
// No dependencies.
`timescale 1ns / 1ps

interface srtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;

  modport source (output valid, data_out, input ready);
  modport sink (input valid, data_out, output ready);
endinterface

// ===== hdl/srtc_regs.sv =====
// Register file and latched time, with the BCD read path for registers 0 to 6.
// Depends on srtc_pkg.
`timescale 1ns / 1ps

module srtc_regs import srtc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wr_cmd_t    wr_i,
  input  logic       latch_i,
  input  tod_t       tod_i,
  input  logic [4:0] rd_addr_i,
  output logic [7:0] rd_byte_o,
  output logic       wp_o
);

  logic [7:0] rf_q [RF_DEPTH];
  tod_t       tod_q;
  logic       is_time;
  logic [7:0] tval;

  // Write the register file; stores start at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RF_DEPTH; i++) rf_q[i] <= '0;
    end else if (wr_i.en) begin
      rf_q[wr_i.addr[4:0]] <= wr_i.data;
    end
  end

  // Latch host time on select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tod_q <= '0;
    end else if (latch_i) begin
      tod_q <= tod_i;
    end
  end

  // Pick the time field, then convert once
  always_comb begin
    unique case (rd_addr_i[2:0])
      REG_SECONDS: tval = {2'b00, tod_q.seconds};
      REG_MINUTES: tval = {2'b00, tod_q.minutes};
      REG_HOURS:   tval = {3'b000, tod_q.hours};
      REG_WEEKDAY: tval = {5'b00000, tod_q.weekday};
      REG_DAY:     tval = {3'b000, tod_q.day};
      REG_MONTH:   tval = {4'b0000, tod_q.month} + 8'd1;
      REG_YEAR:    tval = tod_q.year - YEAR_BASE;
      default:     tval = '0;
    endcase
  end

  assign is_time   = (rd_addr_i[4:3] == 2'b00) && (rd_addr_i[2:0] != 3'd7);
  assign rd_byte_o = is_time ? bcd8(tval) : rf_q[rd_addr_i];
  assign wp_o      = rf_q[CONTROL_REG][WP_BIT];

endmodule

// ===== hdl/srtc_uram.sv =====
// 96-byte battery RAM with registered read and per-entry valid bits.
// Depends on srtc_pkg.
`timescale 1ns / 1ps

module srtc_uram import srtc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wr_cmd_t    wr_i,
  input  logic       rd_en_i,
  input  logic [6:0] rd_addr_i,
  output logic [7:0] rd_data_o
);

  logic [7:0]            mem [URAM_DEPTH];
  logic [URAM_DEPTH-1:0] valid_q;
  logic [7:0]            rd_data_q;

  // Mark entries written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  // Write and read ports; unwritten entries read as zero
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem[rd_addr_i] : 8'h00;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/spi_rtc_register_port_core.sv =====
// Top level of the SPI RTC register port: bus sequencing, result stage, output.
// Depends on srtc_pkg, srtc_in_if, srtc_out_if, srtc_regs and srtc_uram.
`timescale 1ns / 1ps
//
// Channel  Dir  Modport  Payload
// in_i     in   sink     operation, data_in, time_* fields
// out_o    out  source   data_out
//
// Each accepted item yields one result byte; one item per cycle unless the output
// stalls. State, register file and RAM update at the accept edge; the RAM read
// is registered there and enters the output register when the result stage moves.
// Reset clears control state; RAM entries read zero until written (valid bits).
// A stalled output holds the result stage, which then holds off in_i.ready.

`include "spi_rtc_register_port_core_assert.svh"

module spi_rtc_register_port_core import srtc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  srtc_in_if.sink    in_i,
  srtc_out_if.source out_o
);

  logic       phase_q;
  logic [7:0] addr_q;
  logic       s1_valid_q;
  logic       s1_ram_q;
  logic [7:0] s1_byte_q;
  logic       out_valid_q;
  logic [7:0] out_data_q;

  logic       in_acc;
  logic       s1_adv;
  logic       is_xfer;
  logic       is_data;
  logic       writable;
  logic       is_ram;
  logic       wp;
  logic       ram_rd_en;
  logic [6:0] a7;
  logic [6:0] ram_idx;
  logic [7:0] reg_byte;
  logic [7:0] ram_byte;
  logic [7:0] s1_byte_d;
  wr_cmd_t    rf_wr;
  wr_cmd_t    ram_wr;
  tod_t       tod;

  // Handshake: the result stage moves when the output slot frees up
  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  // Decode the transfer against the current address
  assign is_xfer  = in_i.operation == OP_TRANSFER;
  assign is_data  = is_xfer && phase_q;
  assign a7       = addr_q[6:0];
  assign is_ram   = a7[6:5] != 2'b00;
  assign ram_idx  = a7 - 7'h20;
  assign writable = addr_q[7] && ((addr_q[4:0] == CONTROL_REG) || !wp);

  assign rf_wr     = '{en: in_acc && is_data && writable && !is_ram,
                       addr: a7, data: in_i.data_in};
  assign ram_wr    = '{en: in_acc && is_data && writable && is_ram,
                       addr: ram_idx, data: in_i.data_in};
  assign ram_rd_en = in_acc && is_data && !writable && is_ram;

  assign tod = '{seconds: in_i.time_seconds, minutes: in_i.time_minutes,
                 hours: in_i.time_hours, weekday: in_i.time_weekday,
                 day: in_i.time_day, month: in_i.time_month, year: in_i.time_year};

  srtc_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rf_wr),
    .latch_i   (in_acc && (in_i.operation == OP_SELECT)),
    .tod_i     (tod),
    .rd_addr_i (a7[4:0]),
    .rd_byte_o (reg_byte),
    .wp_o      (wp)
  );

  srtc_uram u_uram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (ram_wr),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_idx),
    .rd_data_o (ram_byte)
  );

  // Result byte for everything but a RAM read
  assign s1_byte_d = (is_data && !writable) ? reg_byte : IDLE_BYTE;

  // Advance address phase and address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      addr_q  <= '0;
    end else if (in_acc) begin
      priority if (in_i.operation == OP_DESELECT || in_i.operation == OP_SELECT) begin
        phase_q <= 1'b0;
      end else if (is_xfer && !phase_q) begin
        phase_q <= 1'b1;
        addr_q  <= in_i.data_in;
      end else if (is_data) begin
        addr_q  <= addr_q + 8'd1;
      end else begin
        // Hold on the unused operation code
        phase_q <= phase_q;
      end
    end
  end

  // Result stage: hold while full and the output is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_ram_q   <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
      s1_ram_q   <= ram_rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= s1_byte_d;
    end
  end

  // Output register: merge the RAM read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_data_q <= s1_ram_q ? ram_byte : s1_byte_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = out_data_q;

  `SRTC_ASSERT_NEXT(a_ram_tag, ram_rd_en, s1_valid_q && s1_ram_q, "RAM read lost its tag")
  `SRTC_ASSERT_NEXT(a_addr_inc, in_acc && is_data, addr_q == 8'($past(addr_q) + 8'd1),
                    "address did not advance after a data transfer")
  `SRTC_ASSERT_NEXT(a_ctrl_idle, in_acc && !is_xfer, !s1_ram_q && (s1_byte_q == IDLE_BYTE),
                    "non-transfer item produced a data byte")
  `SRTC_ASSERT_NOW(a_ready_full, !in_i.ready, s1_valid_q && out_valid_q,
                   "input stalled with a free result stage")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for spi_rtc_register_port_core: directed bus table with typed
// bytes, then random select/address/data sequences checked against a cycle-free predictor.
// Depends on srtc_pkg, srtc_in_if, srtc_out_if and the core RTL.
`timescale 1ns / 1ps

module tb;
  import srtc_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 11;
  localparam int BUS_ITEMS     = 430;   // directed plus about 400 random
  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
  localparam int HOLD_AFTER    = 150;   // results seen before the hold
  localparam int IDLE_LIMIT    = 2000;  // cycles without any transfer
  localparam int DRAIN_CYCLES  = 10;
  localparam int REPORT_LIMIT  = 10;

  // Unused operation code, ignored by the block
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [6:0] URAM_BASE = 7'h20;

  localparam tod_t TOD_ZERO = '0;
  localparam tod_t TOD_MAX  = '{seconds: 6'd59, minutes: 6'd59, hours: 5'd23, weekday: 3'd6,
                                day: 5'd31, month: 4'd11, year: 8'd199};
  localparam tod_t TOD_OVER = '{seconds: 6'd63, minutes: 6'd63, hours: 5'd31, weekday: 3'd7,
                                day: 5'd0, month: 4'd15, year: 8'd0};

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] din;
    tod_t       tod;
  } bus_item_t;

  typedef struct packed {
    bus_item_t  item;
    logic       typed;
    logic [7:0] want;
  } bus_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  srtc_in_if  in_if ();
  srtc_out_if out_if ();

  spi_rtc_register_port_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow of the chip: bus phase, address pointer, latched time, stores
  logic       addr_taken = 1'b0;
  logic [7:0] cur_addr   = '0;
  tod_t       held_tod   = '0;
  logic [7:0] reg_shadow [RF_DEPTH]   = '{default: '0};
  logic [7:0] nvram_shadow [URAM_DEPTH] = '{default: '0};

  logic [7:0] data_out_q [$];
  logic [7:0] want_byte;
  int errors     = 0;
  int checked    = 0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int n_selects  = 0;
  int n_writes   = 0;
  int n_reads    = 0;
  int n_blocked  = 0;

  function automatic logic [7:0] to_bcd(logic [7:0] v);
    logic [7:0] tens;
    logic [7:0] ones;
    tens = v / 8'd10;
    ones = v % 8'd10;
    return {tens[3:0], ones[3:0]};
  endfunction

  // Advance the shadow by one bus item and return the byte shifted out
  function logic [7:0] rtc_bus_byte(bus_item_t it);
    logic [7:0] a;
    logic [6:0] a7;
    logic [7:0] res;
    logic       wr_ok;
    res = IDLE_BYTE;
    case (it.op)
      OP_DESELECT: addr_taken = 1'b0;
      OP_SELECT: begin
        held_tod   = it.tod;
        addr_taken = 1'b0;
        n_selects++;
      end
      OP_TRANSFER: begin
        if (!addr_taken) begin
          cur_addr   = it.din;
          addr_taken = 1'b1;
        end else begin
          a  = cur_addr;
          a7 = a[6:0];
          // control register stays writable under write protect
          wr_ok = a[7] && (a[4:0] == CONTROL_REG || !reg_shadow[CONTROL_REG][WP_BIT]);
          if (wr_ok) begin
            if (a7 >= URAM_BASE) nvram_shadow[a7 - URAM_BASE] = it.din;
            else reg_shadow[a7[4:0]] = it.din;
            n_writes++;
          end else begin
            if (a[7]) n_blocked++;
            else n_reads++;
            if (a7 >= URAM_BASE) begin
              res = nvram_shadow[a7 - URAM_BASE];
            end else if (a7 > 7'(REG_YEAR)) begin
              res = reg_shadow[a7[4:0]];
            end else begin
              case (a7[2:0])
                REG_SECONDS: res = to_bcd(8'(held_tod.seconds));
                REG_MINUTES: res = to_bcd(8'(held_tod.minutes));
                REG_HOURS:   res = to_bcd(8'(held_tod.hours));
                REG_WEEKDAY: res = to_bcd(8'(held_tod.weekday));
                REG_DAY:     res = to_bcd(8'(held_tod.day));
                REG_MONTH:   res = to_bcd(8'(held_tod.month) + 8'd1);
                REG_YEAR:    res = to_bcd(held_tod.year - YEAR_BASE);
                default: ;
              endcase
            end
          end
          cur_addr = a + 8'd1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly legal time, sometimes every bit of every field at random
  function automatic tod_t rand_tod();
    tod_t t;
    if ($urandom_range(0, 3) == 0) begin
      t = tod_t'({$urandom, $urandom});
    end else begin
      t.seconds = 6'($urandom_range(0, 59));
      t.minutes = 6'($urandom_range(0, 59));
      t.hours   = 5'($urandom_range(0, 23));
      t.weekday = 3'($urandom_range(0, 6));
      t.day     = 5'($urandom_range(1, 31));
      t.month   = 4'($urandom_range(0, 11));
      t.year    = 8'($urandom_range(100, 199));
    end
    return t;
  endfunction

  // Offer one item in bursts with random gaps; hold it until the transfer
  task automatic send_item(input bus_item_t it, input logic typed, input logic [7:0] want);
    logic [7:0] exp_byte;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid        <= 1'b1;
    in_if.operation    <= it.op;
    in_if.data_in      <= it.din;
    in_if.time_seconds <= it.tod.seconds;
    in_if.time_minutes <= it.tod.minutes;
    in_if.time_hours   <= it.tod.hours;
    in_if.time_weekday <= it.tod.weekday;
    in_if.time_day     <= it.tod.day;
    in_if.time_month   <= it.tod.month;
    in_if.time_year    <= it.tod.year;
    // ready is settled by the falling edge; the transfer lands on the next rise
    do @(negedge clk_i); while (!in_if.ready);
    exp_byte = rtc_bus_byte(it);
    data_out_q.push_back(typed ? want : exp_byte);
    if (it.op != OP_UNUSED) items_sent++;
    @(posedge clk_i);
  endtask

  // Check every result transfer against the oldest expected byte
  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (data_out_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("[%0t] result 0x%02h with nothing expected", $realtime, out_if.data_out);
      end else begin
        want_byte = data_out_q.pop_front();
        checked++;
        if (out_if.data_out !== want_byte) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("[%0t] data_out mismatch: expected 0x%02h, got 0x%02h",
                     $realtime, want_byte, out_if.data_out);
        end
      end
    end
  end

  // Drop the run when neither channel moves for too long
  always @(negedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d results pending",
                 idle_cycles, data_out_q.size());
        $display("** spi_rtc_register_port_core: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: stretches of full rate, random stalls, and one long hold-off
  initial begin : receiver
    int  run;
    int  mode;
    bit  held;
    out_if.ready = 1'b0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && checked >= HOLD_AFTER) begin
        held = 1'b1;
        @(posedge clk_i);
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      run  = $urandom_range(1, 32);
      mode = $urandom_range(0, 3);
      repeat (run) begin
        @(posedge clk_i);
        case (mode)
          0, 1:    out_if.ready <= 1'b1;
          2:       out_if.ready <= ($urandom_range(0, 3) != 0);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    bus_row_t   dir_tab [28];
    bus_item_t  it;
    int         pick;
    int         nbytes;

    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.operation    = OP_DESELECT;
    in_if.data_in      = '0;
    in_if.time_seconds = '0;
    in_if.time_minutes = '0;
    in_if.time_hours   = '0;
    in_if.time_weekday = '0;
    in_if.time_day     = '0;
    in_if.time_month   = '0;
    in_if.time_year    = '0;

    // Directed bus traffic: reset values, time extremes, write protect, wrap, ignored code
    dir_tab = '{
      '{'{OP_TRANSFER, 8'h05, TOD_ZERO}, 1'b1, 8'hFF},  // address straight after reset
      '{'{OP_TRANSFER, 8'hC3, TOD_ZERO}, 1'b1, 8'h01},  // month reads as month + 1
      '{'{OP_SELECT,   8'hFF, TOD_MAX},  1'b1, 8'hFF},
      '{'{OP_TRANSFER, 8'h00, TOD_ZERO}, 1'b1, 8'hFF},
      '{'{OP_TRANSFER, 8'h3C, TOD_ZERO}, 1'b1, 8'h59},
      '{'{OP_TRANSFER, 8'hA5, TOD_ZERO}, 1'b1, 8'h59},
      '{'{OP_TRANSFER, 8'h5A, TOD_ZERO}, 1'b1, 8'h23},
      '{'{OP_TRANSFER, 8'hFF, TOD_ZERO}, 1'b1, 8'h06},
      '{'{OP_TRANSFER, 8'h00, TOD_ZERO}, 1'b1, 8'h31},
      '{'{OP_TRANSFER, 8'h81, TOD_ZERO}, 1'b1, 8'h12},
      '{'{OP_TRANSFER, 8'h7E, TOD_ZERO}, 1'b1, 8'h99},
      '{'{OP_DESELECT, 8'hFF, TOD_MAX},  1'b1, 8'hFF},
      '{'{OP_TRANSFER, 8'h8F, TOD_ZERO}, 1'b1, 8'hFF},
      '{'{OP_TRANSFER, 8'h40, TOD_ZERO}, 1'b1, 8'hFF},  // set write protect
      '{'{OP_TRANSFER, 8'h3C, TOD_ZERO}, 1'b1, 8'h00},  // blocked write reads back
      '{'{OP_DESELECT, 8'h00, TOD_ZERO}, 1'b1, 8'hFF},
      '{'{OP_TRANSFER, 8'hFF, TOD_ZERO}, 1'b1, 8'hFF},
      '{'{OP_TRANSFER, 8'hA5, TOD_ZERO}, 1'b1, 8'h00},  // blocked at top of RAM
      '{'{OP_TRANSFER, 8'h11, TOD_ZERO}, 1'b1, 8'h59},  // address wrapped to zero
      '{'{OP_UNUSED,   8'hEE, TOD_OVER}, 1'b1, 8'hFF},  // ignored, time not latched
      '{'{OP_TRANSFER, 8'h22, TOD_ZERO}, 1'b0, 8'h00},
      '{'{OP_SELECT,   8'h00, TOD_OVER}, 1'b1, 8'hFF},  // fields above range
      '{'{OP_TRANSFER, 8'h05, TOD_ZERO}, 1'b1, 8'hFF},
      '{'{OP_TRANSFER, 8'h99, TOD_ZERO}, 1'b1, 8'h16},
      '{'{OP_TRANSFER, 8'h66, TOD_ZERO}, 1'b1, 8'hF6},  // year below 100 wraps
      '{'{OP_DESELECT, 8'hFF, TOD_OVER}, 1'b1, 8'hFF},
      '{'{OP_TRANSFER, 8'h8F, TOD_ZERO}, 1'b1, 8'hFF},
      '{'{OP_TRANSFER, 8'h00, TOD_ZERO}, 1'b0, 8'h00}   // control write under protect
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    // Random part: mostly whole accesses, some raw noise
    while (items_sent < BUS_ITEMS) begin
      if ($urandom_range(0, 4) != 0) begin
        it.op  = OP_SELECT;
        it.din = 8'($urandom);
        it.tod = rand_tod();
        send_item(it, 1'b0, 8'h00);
        it.op = OP_TRANSFER;
        pick  = $urandom_range(0, 3);
        if (pick == 0) begin
          it.din = {1'b1, 2'b00, CONTROL_REG};
        end else if (pick == 1) begin
          // time registers, control, RAM start and end share few addresses
          it.din = {1'($urandom), ($urandom_range(0, 1) != 0) ?
                   7'($urandom_range(0, 7'h27)) : 7'($urandom_range(7'h70, 7'h7F))};
        end else begin
          it.din = 8'($urandom);
        end
        send_item(it, 1'b0, 8'h00);
        nbytes = $urandom_range(1, 8);
        for (int k = 0; k < nbytes; k++) begin
          it.din = 8'($urandom);
          if (pick == 0 && k == 0) it.din[WP_BIT] = ($urandom_range(0, 3) == 0);
          send_item(it, 1'b0, 8'h00);
        end
        if ($urandom_range(0, 2) != 0) begin
          it.op = OP_DESELECT;
          send_item(it, 1'b0, 8'h00);
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          it.op  = 2'($urandom_range(0, 3));
          it.din = 8'($urandom);
          it.tod = rand_tod();
          send_item(it, 1'b0, 8'h00);
        end
      end
    end
    in_if.valid <= 1'b0;

    while (data_out_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d bus items: %0d selects, %0d writes, %0d reads, %0d blocked writes;",
             items_sent, n_selects, n_writes, n_reads, n_blocked);
    $display("checked %0d result bytes, %0d mismatches.", checked, errors);
    if (errors == 0 && data_out_q.size() == 0) begin
      $display("** spi_rtc_register_port_core: PASSED **");
    end else begin
      $display("** spi_rtc_register_port_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== spi_rtc_register_port_core.f =====
+incdir+hdl
hdl/srtc_pkg.sv
hdl/srtc_in_if.sv
hdl/srtc_out_if.sv
hdl/srtc_regs.sv
hdl/srtc_uram.sv
hdl/spi_rtc_register_port_core.sv
tb/sv/tb.sv
